[rtl/lmm_pkg.sv]
// Shared types, constants and helpers for the localization mode machine.
// Used by lmm_in_stage, lmm_core and localization_mode_machine_top.
package lmm_pkg;

	// Storage widths for pose handles and the two counters
	localparam int HANDLE_BITS = 16;
	localparam int COUNT_BITS  = 8;

	// Port widths fixed by the interface
	localparam int EVENT_W  = 4;
	localparam int PORT_H_W = 16;
	localparam int CFG_W    = 8;
	localparam int STATE_W  = 3;
	localparam int CNT_O_W  = 8;
	localparam int CFG_IDX_W = 1;

	// Compare width wide enough for both counters and config values
	localparam int CMP_BITS = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [CMP_BITS-1:0]    cmp_t;
	typedef logic [CFG_W-1:0]       cfg_val_t;

	localparam count_t CNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONFIRMATIONS = 1'b0,
		CFG_REJECT_LIMIT  = 1'b1
	} cfg_idx_t;

	// Mode machine states
	typedef enum logic [STATE_W-1:0] {
		ST_UNINIT = 3'd0,
		ST_INIT   = 3'd1,
		ST_RELOC  = 3'd2,
		ST_TRACK  = 3'd3,
		ST_LOST   = 3'd4
	} lmm_state_t;

	// Event codes
	typedef enum logic [EVENT_W-1:0] {
		EV_BEGIN_INIT  = 4'd0,
		EV_BEGIN_RELOC = 4'd1,
		EV_SET_CAND    = 4'd2,
		EV_FAIL        = 4'd3,
		EV_REJECT_CAND = 4'd4,
		EV_OBSERVE     = 4'd5,
		EV_APPLY_TRACK = 4'd6,
		EV_RECORD_REJ  = 4'd7,
		EV_ENTER_LOST  = 4'd8
	} lmm_event_t;

	// One request as held in the input register
	typedef struct packed {
		logic [EVENT_W-1:0]  mode;
		logic [PORT_H_W-1:0] pose_handle;
		logic                pose_finite;
		logic                within_limits;
	} lmm_item_t;

	// One result as held in the result register
	typedef struct packed {
		logic                op_ok;
		logic [STATE_W-1:0]  loc_state;
		logic                has_valid;
		logic [CNT_O_W-1:0]  confirm_count;
		logic                accepted;
		logic                confirmed;
		logic [PORT_H_W-1:0] correction_id;
		logic [PORT_H_W-1:0] pending_id;
	} lmm_result_t;

	// Handshake between the input register and the core
	typedef struct packed {
		logic      valid;
		lmm_item_t item;
	} lmm_req_t;

	// Confirmation target: zero counts as one, clamp to counter range
	function automatic count_t target_count(input cfg_val_t need);
		cmp_t t;
		t = cmp_t'(need);
		if (t == '0)
			t = cmp_t'(1);
		if (t > cmp_t'(CNT_MAX))
			t = cmp_t'(CNT_MAX);
		return count_t'(t);
	endfunction

	// Saturating increment
	function automatic count_t sat_inc(input count_t c);
		return (c == CNT_MAX) ? c : count_t'(c + count_t'(1));
	endfunction

endpackage

[rtl/lmm_in_stage.sv]
// Input register of the localization mode machine: holds one request.
// Depends on lmm_pkg for the request types.
module lmm_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lmm_pkg::lmm_item_t in_item,
	input  logic               adv,
	output lmm_pkg::lmm_req_t  req
);

	logic               valid_s1;
	lmm_pkg::lmm_item_t item_s1;
	logic               take;

	// Stall only when the held request cannot move on this cycle
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

	assign req.valid = valid_s1;
	assign req.item  = item_s1;

endmodule

[rtl/lmm_core.sv]
// Mode state, counters, handle registers and result register.
// Depends on lmm_pkg for states, events, helpers and request/result types.
module lmm_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  lmm_pkg::cfg_idx_t    cfg_sel,
	input  lmm_pkg::cfg_val_t    cfg_val,
	input  lmm_pkg::lmm_req_t    req,
	output logic                 adv,
	input  logic                 out_stall,
	output logic                 out_valid,
	output lmm_pkg::lmm_result_t result
);

	// Configuration registers
	lmm_pkg::cfg_val_t   need_q;
	lmm_pkg::cfg_val_t   limit_q;

	// Machine state
	lmm_pkg::lmm_state_t state_q, state_d;
	logic                valid_q, valid_d;
	lmm_pkg::count_t     conf_q, conf_d;
	lmm_pkg::count_t     rej_q, rej_d;
	lmm_pkg::handle_t    prior_q, prior_d;
	lmm_pkg::handle_t    pend_q, pend_d;
	lmm_pkg::handle_t    corr_q, corr_d;

	// Result register
	logic                 valid_s2;
	lmm_pkg::lmm_result_t res_s2;

	// Event decode helpers
	lmm_pkg::lmm_event_t evt;
	lmm_pkg::handle_t    h;
	lmm_pkg::count_t     target;
	lmm_pkg::count_t     conf_inc;
	lmm_pkg::count_t     rej_inc;
	logic                searching;
	logic                ok, acc, conf;

	assign adv = req.valid && (!valid_s2 || !out_stall);

	assign evt       = lmm_pkg::lmm_event_t'(req.item.mode);
	assign h         = lmm_pkg::handle_t'(req.item.pose_handle);
	assign target    = lmm_pkg::target_count(need_q);
	assign conf_inc  = lmm_pkg::sat_inc(conf_q);
	assign rej_inc   = lmm_pkg::sat_inc(rej_q);
	assign searching = (state_q == lmm_pkg::ST_INIT) || (state_q == lmm_pkg::ST_RELOC);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q  <= lmm_pkg::cfg_val_t'(1);
			limit_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				lmm_pkg::CFG_CONFIRMATIONS: need_q  <= cfg_val;
				lmm_pkg::CFG_REJECT_LIMIT:  limit_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// Next state and per-event flags
	always_comb begin
		state_d = state_q;
		valid_d = valid_q;
		conf_d  = conf_q;
		rej_d   = rej_q;
		prior_d = prior_q;
		pend_d  = pend_q;
		corr_d  = corr_q;
		ok      = 1'b0;
		acc     = 1'b0;
		conf    = 1'b0;
		case (evt)
			lmm_pkg::EV_BEGIN_INIT, lmm_pkg::EV_BEGIN_RELOC: begin
				if (evt == lmm_pkg::EV_BEGIN_INIT) begin
					state_d = lmm_pkg::ST_INIT;
					valid_d = 1'b0;
				end else begin
					state_d = lmm_pkg::ST_RELOC;
				end
				prior_d = h;
				pend_d  = h;
				conf_d  = '0;
				rej_d   = '0;
			end
			lmm_pkg::EV_SET_CAND: begin
				if (searching && req.item.pose_finite) begin
					prior_d = h;
					pend_d  = h;
					conf_d  = '0;
					ok      = 1'b1;
				end
			end
			lmm_pkg::EV_FAIL: begin
				if (state_q == lmm_pkg::ST_INIT) begin
					state_d = lmm_pkg::ST_UNINIT;
					valid_d = 1'b0;
				end else if (state_q == lmm_pkg::ST_RELOC) begin
					state_d = lmm_pkg::ST_LOST;
				end
				conf_d = '0;
				rej_d  = '0;
			end
			lmm_pkg::EV_REJECT_CAND: begin
				if (searching) begin
					pend_d = prior_q;
					conf_d = '0;
				end
			end
			lmm_pkg::EV_OBSERVE: begin
				if (searching) begin
					if (!(req.item.pose_finite && req.item.within_limits)) begin
						pend_d = prior_q;
						conf_d = '0;
					end else begin
						acc    = 1'b1;
						conf_d = conf_inc;
						// Enough confirmations: commit candidate and track
						if (conf_inc >= target) begin
							pend_d  = h;
							corr_d  = h;
							valid_d = 1'b1;
							state_d = lmm_pkg::ST_TRACK;
							conf_d  = target;
							rej_d   = '0;
							conf    = 1'b1;
						end
					end
				end
			end
			lmm_pkg::EV_APPLY_TRACK: begin
				if (state_q == lmm_pkg::ST_TRACK && req.item.pose_finite) begin
					corr_d  = h;
					valid_d = 1'b1;
					rej_d   = '0;
					ok      = 1'b1;
				end
			end
			lmm_pkg::EV_RECORD_REJ: begin
				if (state_q == lmm_pkg::ST_TRACK) begin
					rej_d = rej_inc;
					// A zero limit never trips
					if (limit_q != '0 &&
					    lmm_pkg::cmp_t'(rej_inc) >= lmm_pkg::cmp_t'(limit_q)) begin
						state_d = lmm_pkg::ST_LOST;
						conf_d  = '0;
						rej_d   = '0;
						ok      = 1'b1;
					end
				end
			end
			lmm_pkg::EV_ENTER_LOST: begin
				state_d = lmm_pkg::ST_LOST;
				conf_d  = '0;
				rej_d   = '0;
			end
			default: ;
		endcase
	end

	// State registers, updated as each request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmm_pkg::ST_UNINIT;
			valid_q <= 1'b0;
			conf_q  <= '0;
			rej_q   <= '0;
			prior_q <= '0;
			pend_q  <= '0;
			corr_q  <= '0;
		end else if (adv) begin
			state_q <= state_d;
			valid_q <= valid_d;
			conf_q  <= conf_d;
			rej_q   <= rej_d;
			prior_q <= prior_d;
			pend_q  <= pend_d;
			corr_q  <= corr_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.op_ok         <= ok;
			res_s2.loc_state     <= state_d;
			res_s2.has_valid     <= valid_d;
			res_s2.confirm_count <= lmm_pkg::CNT_O_W'(conf_d);
			res_s2.accepted      <= acc;
			res_s2.confirmed     <= conf;
			res_s2.correction_id <= lmm_pkg::PORT_H_W'(corr_d);
			res_s2.pending_id    <= lmm_pkg::PORT_H_W'(pend_d);
		end
	end

	assign out_valid = valid_s2;
	assign result    = res_s2;

endmodule

[rtl/localization_mode_machine_top.sv]
// Top level of the localization mode machine.
// Depends on lmm_pkg, lmm_in_stage and lmm_core.

// Localization mode machine: one event request in, one result out. Takes a
// new request every cycle while in_stall is low; each result passes from
// the input register through the state update into the result register,
// and the loop through the mode state and counters sets that rate.
// A stalled result holds while the input register keeps taking one more
// request. Configuration writes are taken at any time, but must be issued
// only while no request is in flight.
module localization_mode_machine_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// event requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic [15:0] pose_handle,
	input  logic        pose_finite,
	input  logic        within_limits,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        op_ok,
	output logic [2:0]  loc_state,
	output logic        has_valid,
	output logic [7:0]  confirm_count,
	output logic        accepted,
	output logic        confirmed,
	output logic [15:0] correction_id,
	output logic [15:0] pending_id
);

	lmm_pkg::lmm_item_t   in_item;
	lmm_pkg::lmm_req_t    req;
	lmm_pkg::lmm_result_t result;
	logic                 adv;

	assign cfg_ready = 1'b1;

	assign in_item.mode          = mode;
	assign in_item.pose_handle   = pose_handle;
	assign in_item.pose_finite   = pose_finite;
	assign in_item.within_limits = within_limits;

	lmm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.adv      (adv),
		.req      (req)
	);

	lmm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_sel   (lmm_pkg::cfg_idx_t'(cfg_index)),
		.cfg_val   (cfg_data),
		.req       (req),
		.adv       (adv),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result)
	);

	// Unpack the result register
	assign op_ok         = result.op_ok;
	assign loc_state     = result.loc_state;
	assign has_valid     = result.has_valid;
	assign confirm_count = result.confirm_count;
	assign accepted      = result.accepted;
	assign confirmed     = result.confirmed;
	assign correction_id = result.correction_id;
	assign pending_id    = result.pending_id;

`ifndef SYNTHESIS
	// Input stalls only when both registers are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// A confirming observation lands in tracking with a valid correction
	a_confirm_track: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && confirmed) |->
			(accepted && has_valid && loc_state == lmm_pkg::ST_TRACK))
		else $error("confirmation without tracking state");

	// An accepted observation always leaves a nonzero count
	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (confirm_count != 8'd0))
		else $error("accepted observation with zero count");
`endif

endmodule

[test/localization_mode_machine_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for localization_mode_machine_top: event requests are
// run through an in-bench model of the mode machine and each result is compared.
// Depends on lmm_pkg and the RTL under rtl/.
module localization_mode_machine_top_test;
	import lmm_pkg::*;

	// Event codes outside the defined set
	localparam logic [3:0] EV_UNKNOWN_LO = 4'd9;
	localparam logic [3:0] EV_UNKNOWN_HI = 4'd15;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index     = '0;
	logic [7:0]  cfg_data      = '0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [3:0]  mode          = '0;
	logic [15:0] pose_handle   = '0;
	logic        pose_finite   = 1'b0;
	logic        within_limits = 1'b0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic        op_ok;
	logic [2:0]  loc_state;
	logic        has_valid;
	logic [7:0]  confirm_count;
	logic        accepted;
	logic        confirmed;
	logic [15:0] correction_id;
	logic [15:0] pending_id;

	localization_mode_machine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.pose_handle   (pose_handle),
		.pose_finite   (pose_finite),
		.within_limits (within_limits),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.op_ok         (op_ok),
		.loc_state     (loc_state),
		.has_valid     (has_valid),
		.confirm_count (confirm_count),
		.accepted      (accepted),
		.confirmed     (confirmed),
		.correction_id (correction_id),
		.pending_id    (pending_id)
	);

	// Requests waiting to be driven, results waiting to arrive
	lmm_item_t   event_q[$];
	lmm_result_t want_q[$];
	int          queued     = 0;
	int          mismatches = 0;
	int          snd_idle_pct = 0;
	int          rcv_idle_pct = 0;

	// Model copy of the configuration and the machine state
	cfg_val_t   need_cfg  = 8'd1;
	cfg_val_t   limit_cfg = 8'd0;
	lmm_state_t m_state   = ST_UNINIT;
	logic       m_valid   = 1'b0;
	count_t     m_confirm = '0;
	count_t     m_reject  = '0;
	handle_t    m_prior   = '0;
	handle_t    m_pending = '0;
	handle_t    m_corr    = '0;

	initial forever #1 clk = ~clk;

	// Advance the model by one event and return the result it should produce
	function automatic lmm_result_t apply_event(input lmm_item_t it);
		lmm_result_t r;
		handle_t     h;
		logic        searching;
		int          goal;
		r = '0;
		h = handle_t'(it.pose_handle);
		searching = (m_state == ST_INIT) || (m_state == ST_RELOC);
		goal = (need_cfg == 0) ? 1 : int'(need_cfg);
		if (goal > int'(CNT_MAX))
			goal = int'(CNT_MAX);
		case (it.mode)
			EV_BEGIN_INIT, EV_BEGIN_RELOC: begin
				m_state = (it.mode == EV_BEGIN_INIT) ? ST_INIT : ST_RELOC;
				if (it.mode == EV_BEGIN_INIT)
					m_valid = 1'b0;
				m_prior   = h;
				m_pending = h;
				m_confirm = '0;
				m_reject  = '0;
			end
			EV_SET_CAND: begin
				if (searching && it.pose_finite) begin
					m_prior   = h;
					m_pending = h;
					m_confirm = '0;
					r.op_ok   = 1'b1;
				end
			end
			EV_FAIL: begin
				if (m_state == ST_INIT) begin
					m_state = ST_UNINIT;
					m_valid = 1'b0;
				end else if (m_state == ST_RELOC) begin
					m_state = ST_LOST;
				end
				m_confirm = '0;
				m_reject  = '0;
			end
			EV_REJECT_CAND: begin
				if (searching) begin
					m_pending = m_prior;
					m_confirm = '0;
				end
			end
			EV_OBSERVE: begin
				if (searching && !(it.pose_finite && it.within_limits)) begin
					m_pending = m_prior;
					m_confirm = '0;
				end else if (searching) begin
					if (m_confirm != CNT_MAX)
						m_confirm = m_confirm + 1'b1;
					r.accepted = 1'b1;
					if (int'(m_confirm) >= goal) begin
						m_pending   = h;
						m_corr      = h;
						m_valid     = 1'b1;
						m_state     = ST_TRACK;
						m_confirm   = count_t'(goal);
						m_reject    = '0;
						r.confirmed = 1'b1;
					end
				end
			end
			EV_APPLY_TRACK: begin
				if (m_state == ST_TRACK && it.pose_finite) begin
					m_corr   = h;
					m_valid  = 1'b1;
					m_reject = '0;
					r.op_ok  = 1'b1;
				end
			end
			EV_RECORD_REJ: begin
				if (m_state == ST_TRACK) begin
					if (m_reject != CNT_MAX)
						m_reject = m_reject + 1'b1;
					// hitting a nonzero limit drops tracking
					if (limit_cfg != 0 && int'(m_reject) >= int'(limit_cfg)) begin
						m_state   = ST_LOST;
						m_confirm = '0;
						m_reject  = '0;
						r.op_ok   = 1'b1;
					end
				end
			end
			EV_ENTER_LOST: begin
				m_state   = ST_LOST;
				m_confirm = '0;
				m_reject  = '0;
			end
			default: ;
		endcase
		r.loc_state     = m_state;
		r.has_valid     = m_valid;
		r.confirm_count = m_confirm;
		r.correction_id = m_corr[PORT_H_W-1:0];
		r.pending_id    = m_pending[PORT_H_W-1:0];
		return r;
	endfunction

	// Request driver: takes the next pending event once the current one is accepted
	always @(posedge clk) begin : drive_events
		lmm_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				nxt.mode          = mode;
				nxt.pose_handle   = pose_handle;
				nxt.pose_finite   = pose_finite;
				nxt.within_limits = within_limits;
				want_q.insert(want_q.size(), apply_event(nxt));
			end
			if (!in_valid || !in_stall) begin
				if (event_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					nxt = event_q[0];
					event_q.delete(0);
					mode          <= nxt.mode;
					pose_handle   <= nxt.pose_handle;
					pose_finite   <= nxt.pose_finite;
					within_limits <= nxt.within_limits;
					in_valid      <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		lmm_result_t want;
		logic        bad;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request outstanding", $realtime);
				end else begin
					want = want_q[0];
					want_q.delete(0);
					bad = (op_ok !== want.op_ok) || (loc_state !== want.loc_state) ||
					      (has_valid !== want.has_valid) ||
					      (confirm_count !== want.confirm_count) ||
					      (accepted !== want.accepted) || (confirmed !== want.confirmed) ||
					      (correction_id !== want.correction_id) ||
					      (pending_id !== want.pending_id);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch ok/st/val/cnt/acc/conf/corr/pend", $realtime);
							$display("  expected %b %0d %b %0d %b %b %h %h", want.op_ok,
							         want.loc_state, want.has_valid, want.confirm_count,
							         want.accepted, want.confirmed, want.correction_id,
							         want.pending_id);
							$display("  actual   %b %0d %b %0d %b %b %h %h", op_ok, loc_state,
							         has_valid, confirm_count, accepted, confirmed,
							         correction_id, pending_id);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	task automatic push_event(input logic [3:0] m, input logic [15:0] h,
	                          input logic fin, input logic lim);
		lmm_item_t it;
		it.mode          = m;
		it.pose_handle   = h;
		it.pose_finite   = fin;
		it.within_limits = lim;
		event_q.insert(event_q.size(), it);
		queued++;
	endtask

	task automatic push_noise();
		push_event(4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)),
		           1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// Wait until every request is out and answered, then let the pipe settle
	task automatic wait_drained();
		do @(negedge clk);
		while (event_q.size() != 0 || in_valid || want_q.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_val_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CONFIRMATIONS: need_cfg  = val;
			CFG_REJECT_LIMIT:  limit_cfg = val;
			default: ;
		endcase
	endtask

	task automatic configure(input cfg_val_t need, input cfg_val_t limit);
		wait_drained();
		write_reg(CFG_CONFIRMATIONS, need);
		write_reg(CFG_REJECT_LIMIT, limit);
		@(negedge clk);
	endtask

	// One localization attempt: begin, candidates, observations, then tracking or an early give-up
	task automatic queue_session(input bit may_break);
		int   goal;
		int   fail_at;
		int   n_obs;
		int   k;
		logic fin;
		logic lim;
		goal = (need_cfg == 0) ? 1 : int'(need_cfg);
		if (goal > int'(CNT_MAX))
			goal = int'(CNT_MAX);
		fail_at = (may_break && $urandom_range(9) == 0) ? int'($urandom_range(goal - 1)) : -1;
		push_event($urandom_range(1) ? EV_BEGIN_RELOC : EV_BEGIN_INIT,
		           16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
		           1'($urandom_range(1)));
		repeat ($urandom_range(2))
			push_event(EV_SET_CAND, 16'($urandom_range(16'hFFFF)),
			           $urandom_range(7) != 0, 1'($urandom_range(1)));
		if ($urandom_range(7) == 0)
			push_event(EV_REJECT_CAND, 16'($urandom_range(16'hFFFF)),
			           1'($urandom_range(1)), 1'($urandom_range(1)));
		n_obs = goal + int'($urandom_range(1));
		for (k = 0; k < n_obs; k++) begin
			if (k == fail_at) begin
				{fin, lim} = 2'($urandom_range(2));
			end else begin
				fin = 1'b1;
				lim = 1'b1;
			end
			push_event(EV_OBSERVE, 16'($urandom_range(16'hFFFF)), fin, lim);
		end
		// some attempts give up before tracking
		if (may_break && $urandom_range(4) == 0) begin
			push_event($urandom_range(1) ? EV_FAIL : EV_ENTER_LOST,
			           16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
			           1'($urandom_range(1)));
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(1))
				push_event(EV_APPLY_TRACK, 16'($urandom_range(16'hFFFF)),
				           $urandom_range(5) != 0, 1'($urandom_range(1)));
			else
				push_event(EV_RECORD_REJ, 16'($urandom_range(16'hFFFF)),
				           1'($urandom_range(1)), 1'($urandom_range(1)));
		end
		// run of rejections to the limit or one past it, or leave tracking another way
		if (limit_cfg != 0 && (!may_break || $urandom_range(1))) begin
			repeat (int'(limit_cfg) + int'($urandom_range(1)))
				push_event(EV_RECORD_REJ, 16'($urandom_range(16'hFFFF)),
				           1'($urandom_range(1)), 1'($urandom_range(1)));
		end else begin
			push_event($urandom_range(1) ? EV_ENTER_LOST : EV_FAIL,
			           16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
			           1'($urandom_range(1)));
		end
	endtask

	task automatic run_random(input int n);
		int target;
		target = queued + n;
		while (queued < target) begin
			if ($urandom_range(5) == 0)
				push_noise();
			else
				queue_session(1'b1);
		end
	endtask

	// Stimulus and phase control
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// sender mostly busy, receiver mostly stalled
		snd_idle_pct = 9;
		rcv_idle_pct = 76;
		configure(8'd0, 8'd1);

		// directed: wrong-mode events, flags, zero target, limit, unknown codes
		push_event(EV_OBSERVE, 16'hFFFF, 1'b1, 1'b1);
		push_event(EV_SET_CAND, 16'hFFFF, 1'b1, 1'b1);
		push_event(EV_BEGIN_INIT, 16'h0000, 1'b0, 1'b0);
		push_event(EV_SET_CAND, 16'hFFFF, 1'b0, 1'b1);
		push_event(EV_SET_CAND, 16'hFFFF, 1'b1, 1'b0);
		push_event(EV_OBSERVE, 16'h1111, 1'b1, 1'b0);
		push_event(EV_REJECT_CAND, 16'h2222, 1'b0, 1'b0);
		push_event(EV_OBSERVE, 16'hA5A5, 1'b1, 1'b1);
		push_event(EV_APPLY_TRACK, 16'h3333, 1'b0, 1'b1);
		push_event(EV_APPLY_TRACK, 16'hFFFF, 1'b1, 1'b0);
		push_event(EV_RECORD_REJ, 16'h4444, 1'b0, 1'b0);
		push_event(EV_FAIL, 16'h0000, 1'b0, 1'b0);
		push_event(EV_BEGIN_RELOC, 16'h1234, 1'b1, 1'b1);
		push_event(EV_FAIL, 16'hFFFF, 1'b1, 1'b1);
		push_event(EV_BEGIN_INIT, 16'h5A5A, 1'b1, 1'b0);
		push_event(EV_FAIL, 16'h0F0F, 1'b0, 1'b1);
		push_event(EV_ENTER_LOST, 16'hF0F0, 1'b1, 1'b1);
		push_event(EV_UNKNOWN_LO, 16'hFFFF, 1'b1, 1'b1);
		push_event(EV_UNKNOWN_HI, 16'h0000, 1'b1, 1'b1);
		push_event(EV_BEGIN_RELOC, 16'h8000, 1'b0, 1'b1);
		push_event(EV_OBSERVE, 16'h7FFF, 1'b0, 1'b1);
		push_event(EV_OBSERVE, 16'h7FFF, 1'b1, 1'b1);
		push_event(EV_RECORD_REJ, 16'h0001, 1'b1, 1'b1);
		push_event(EV_APPLY_TRACK, 16'h0002, 1'b1, 1'b1);
		push_event(EV_RECORD_REJ, 16'h0003, 1'b1, 1'b1);

		configure(8'd2, 8'd3);
		run_random(350);

		// sender mostly idle, receiver mostly ready; largest settings
		wait_drained();
		snd_idle_pct = 76;
		rcv_idle_pct = 9;
		configure(8'd255, 8'd255);
		queue_session(1'b0);
		configure(8'd4, 8'd0);
		run_random(200);

		// back-to-back traffic
		wait_drained();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		configure(8'd1, 8'd1);
		run_random(160);
		configure(8'd3, 8'd2);
		run_random(160);
		configure(8'd0, 8'd0);
		run_random(100);

		wait_drained();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/lmm_pkg.sv
rtl/lmm_in_stage.sv
rtl/lmm_core.sv
rtl/localization_mode_machine_top.sv
test/localization_mode_machine_top_test.sv
